// ===== sv/lqa_pkg.sv =====
// Package: shared types, constants and helpers for the lock-in quadrature accumulator.
package lqa_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 24;

  localparam logic [CFG_AW-1:0] CFG_ADC_ZERO   = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_PTS_CYCLE  = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_PT_REPEATS = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_CYC_TARGET = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_FREE_RUN   = 3'd4;

  localparam logic [11:0] ADC_ZERO_RST   = 12'd2048;
  localparam logic [8:0]  PTS_CYCLE_RST  = 9'd2;
  localparam logic [15:0] PT_REPEATS_RST = 16'd1;
  localparam logic [23:0] CYC_TARGET_RST = 24'd10;

  localparam logic [11:0] DAC_OFFSET = 12'd2048;
  localparam logic [23:0] CYC_MAX    = 24'hFF_FFFF;
  localparam logic [31:0] CNT_MAX    = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_LOAD   = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic [11:0]        excite;
    logic signed [15:0] ref_i;
    logic signed [15:0] ref_q;
  } tbl_entry_t;

  // sample-side control handed from the front end to the multiply/accumulate path
  typedef struct packed {
    logic               active;
    logic               is_read;
    logic signed [12:0] val;
    logic [31:0]        cnt;
    logic               done;
  } issue_t;

  function automatic logic [12:0] dac_of(input logic [11:0] excite);
    logic [11:0] sum;
    sum = excite + DAC_OFFSET;
    return {1'b1, sum};
  endfunction

endpackage

// ===== sv/lqa_if.sv =====
// Interfaces: input word channel and result word channel.
interface lqa_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [11:0]        adc_sample;
  logic [7:0]         table_index;
  logic signed [11:0] excite_value;
  logic signed [15:0] ref_in_phase;
  logic signed [15:0] ref_quadrature;

  modport source (output valid, op, adc_sample, table_index, excite_value, ref_in_phase,
                  ref_quadrature, input ready);
  modport sink   (input valid, op, adc_sample, table_index, excite_value, ref_in_phase,
                  ref_quadrature, output ready);
endinterface

interface lqa_out_if;
  logic               valid;
  logic               ready;
  logic [12:0]        dac_word;
  logic signed [47:0] sum_in_phase;
  logic signed [47:0] sum_quadrature;
  logic [31:0]        samples_taken;
  logic               done_res;

  modport source (output valid, dac_word, sum_in_phase, sum_quadrature, samples_taken,
                  done_res, input ready);
  modport sink   (input valid, dac_word, sum_in_phase, sum_quadrature, samples_taken,
                  done_res, output ready);
endinterface

// ===== sv/lqa_ctrl.sv =====
// Front end: configuration registers, table sequencing, cycle and sample counting.
module lqa_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lqa_pkg::CFG_AW-1:0]    cfg_index,
  input  logic [lqa_pkg::CFG_DW-1:0]    cfg_data,
  input  logic                          take,
  input  lqa_pkg::op_t                  op,
  input  logic [11:0]                   adc_sample,
  output lqa_pkg::issue_t               issue,
  output logic [lqa_pkg::TBL_AW-1:0]    rd_idx
);
  import lqa_pkg::*;

  logic [11:0] adc_zero_r;
  logic [8:0]  pts_cycle_r;
  logic [15:0] pt_repeats_r;
  logic [23:0] cyc_target_r;
  logic        free_run_r;

  logic [15:0] rep_r, rep_nxt;
  logic [8:0]  pos_r, pos_nxt;
  logic [23:0] cyc_r, cyc_nxt;
  logic [31:0] st_r, st_nxt;

  logic        wrap;
  logic [15:0] reps;
  logic [15:0] rep0;
  logic [16:0] rep1;
  logic [8:0]  pos0;
  logic [23:0] cyc0;
  logic        act;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adc_zero_r   <= ADC_ZERO_RST;
      pts_cycle_r  <= PTS_CYCLE_RST;
      pt_repeats_r <= PT_REPEATS_RST;
      cyc_target_r <= CYC_TARGET_RST;
      free_run_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ADC_ZERO:   adc_zero_r   <= cfg_data[11:0];
        CFG_PTS_CYCLE:  pts_cycle_r  <= cfg_data[8:0];
        CFG_PT_REPEATS: pt_repeats_r <= cfg_data[15:0];
        CFG_CYC_TARGET: cyc_target_r <= cfg_data[23:0];
        CFG_FREE_RUN:   free_run_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    reps = (pt_repeats_r == 16'd0) ? 16'd1 : pt_repeats_r;
    wrap = (pos_r >= pts_cycle_r);
    pos0 = wrap ? 9'd0 : pos_r;
    rep0 = wrap ? 16'd0 : rep_r;
    cyc0 = (wrap && (cyc_r != CYC_MAX)) ? cyc_r + 24'd1 : cyc_r;
    act  = (cyc0 < cyc_target_r) || free_run_r;
    rep1 = {1'b0, rep0} + 17'd1;

    rep_nxt = rep_r;
    pos_nxt = pos_r;
    cyc_nxt = cyc_r;
    st_nxt  = st_r;
    case (op)
      OP_SAMPLE: begin
        cyc_nxt = cyc0;
        if (act) begin
          st_nxt = (st_r != CNT_MAX) ? st_r + 32'd1 : st_r;
          if (rep1 >= {1'b0, reps}) begin
            rep_nxt = 16'd0;
            pos_nxt = pos0 + 9'd1;
          end else begin
            rep_nxt = rep1[15:0];
            pos_nxt = pos0;
          end
        end else begin
          rep_nxt = 16'd0;
          pos_nxt = 9'd0;
        end
      end
      OP_READ: begin
        st_nxt  = 32'd0;
        cyc_nxt = 24'd0;
      end
      default: ;
    endcase

    issue.active  = (op == OP_SAMPLE) && act;
    issue.is_read = (op == OP_READ);
    issue.val     = $signed({1'b0, adc_sample}) - $signed({1'b0, adc_zero_r});
    issue.cnt     = st_r;
    issue.done    = (cyc_r >= cyc_target_r);
    rd_idx        = pos0[TBL_AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_r <= 16'd0;
      pos_r <= 9'd0;
      cyc_r <= 24'd0;
      st_r  <= 32'd0;
    end else if (take) begin
      rep_r <= rep_nxt;
      pos_r <= pos_nxt;
      cyc_r <= cyc_nxt;
      st_r  <= st_nxt;
    end
  end

  a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    take && (op == OP_READ) |=> (st_r == 32'd0) && (cyc_r == 24'd0))
    else $error("sample count or cycle count not cleared by read");

endmodule

// ===== sv/lqa_table.sv =====
// Reference table memory: excitation, in-phase and quadrature entries, registered read.
module lqa_table (
  input  logic                        clk,
  input  logic                        we,
  input  logic [lqa_pkg::TBL_AW-1:0]  wr_idx,
  input  lqa_pkg::tbl_entry_t         wr_data,
  input  logic                        re,
  input  logic [lqa_pkg::TBL_AW-1:0]  rd_idx,
  output lqa_pkg::tbl_entry_t         rd_data
);
  import lqa_pkg::*;

  tbl_entry_t mem [TABLE_DEPTH];
  tbl_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_idx] <= wr_data;
    end
    if (re) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/lqa_mac.sv =====
// Multiply/accumulate path: product stage, accumulators, excitation tracking, result register.
module lqa_mac (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  lqa_pkg::issue_t      issue,
  input  lqa_pkg::tbl_entry_t  entry,
  output logic                 can_take,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [12:0]          dac_word,
  output logic signed [47:0]   sum_in_phase,
  output logic signed [47:0]   sum_quadrature,
  output logic [31:0]          samples_taken,
  output logic                 done_res
);
  import lqa_pkg::*;

  // stage B: issued word, table data arrives alongside
  logic        vb_r;
  issue_t      iss_b_r;

  // stage C: products
  logic               vc_r;
  logic               act_c_r;
  logic               rd_c_r;
  logic signed [28:0] prod_i_c_r;
  logic signed [28:0] prod_q_c_r;
  logic [31:0]        cnt_c_r;
  logic               done_c_r;
  logic [12:0]        dac_c_r;

  logic [11:0]        last_excite_r, last_excite_nxt;
  logic signed [47:0] acc_i_r, acc_q_r;

  // result register
  logic               vo_r;
  logic               rd_o_r;
  logic [12:0]        dac_o_r;
  logic signed [47:0] sum_i_o_r, sum_q_o_r;
  logic [31:0]        cnt_o_r;
  logic               done_o_r;

  logic adv_o, adv_c, mv_b, mv_c;
  logic signed [28:0] prod_i, prod_q;

  always_comb begin
    adv_o    = !vo_r || out_ready;
    adv_c    = !vc_r || adv_o;
    can_take = !vb_r || adv_c;
    mv_b     = vb_r && adv_c;
    mv_c     = vc_r && adv_o;
    prod_i   = iss_b_r.val * entry.ref_i;
    prod_q   = iss_b_r.val * entry.ref_q;
    last_excite_nxt = iss_b_r.active ? entry.excite : last_excite_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r          <= 1'b0;
      vc_r          <= 1'b0;
      vo_r          <= 1'b0;
      last_excite_r <= 12'd0;
      acc_i_r       <= 48'sd0;
      acc_q_r       <= 48'sd0;
    end else begin
      if (take) begin
        vb_r <= 1'b1;
      end else if (mv_b) begin
        vb_r <= 1'b0;
      end
      if (mv_b) begin
        vc_r          <= 1'b1;
        last_excite_r <= last_excite_nxt;
      end else if (mv_c) begin
        vc_r <= 1'b0;
      end
      if (mv_c) begin
        vo_r <= 1'b1;
        if (rd_c_r) begin
          acc_i_r <= 48'sd0;
          acc_q_r <= 48'sd0;
        end else if (act_c_r) begin
          acc_i_r <= acc_i_r + {{19{prod_i_c_r[28]}}, prod_i_c_r};
          acc_q_r <= acc_q_r + {{19{prod_q_c_r[28]}}, prod_q_c_r};
        end
      end else if (out_ready) begin
        vo_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      iss_b_r <= issue;
    end
    if (mv_b) begin
      act_c_r    <= iss_b_r.active;
      rd_c_r     <= iss_b_r.is_read;
      prod_i_c_r <= prod_i;
      prod_q_c_r <= prod_q;
      cnt_c_r    <= iss_b_r.cnt;
      done_c_r   <= iss_b_r.done;
      dac_c_r    <= dac_of(last_excite_nxt);
    end
    if (mv_c) begin
      rd_o_r    <= rd_c_r;
      dac_o_r   <= dac_c_r;
      sum_i_o_r <= rd_c_r ? acc_i_r : 48'sd0;
      sum_q_o_r <= rd_c_r ? acc_q_r : 48'sd0;
      cnt_o_r   <= rd_c_r ? cnt_c_r : 32'd0;
      done_o_r  <= rd_c_r && done_c_r;
    end
  end

  assign out_valid      = vo_r;
  assign dac_word       = dac_o_r;
  assign sum_in_phase   = sum_i_o_r;
  assign sum_quadrature = sum_q_o_r;
  assign samples_taken  = cnt_o_r;
  assign done_res       = done_o_r;

  a_stage_c_held: assert property (@(posedge clk) disable iff (!rst_n)
    vc_r && !adv_o |=> vc_r)
    else $error("product stage dropped a word while stalled");

  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    mv_c && rd_c_r |=> (acc_i_r == 48'sd0) && (acc_q_r == 48'sd0))
    else $error("accumulators not cleared after read");

  a_non_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r && !rd_o_r |-> (sum_i_o_r == 48'sd0) && (sum_q_o_r == 48'sd0)
                        && (cnt_o_r == 32'd0) && !done_o_r)
    else $error("non-read word carries sums");

  a_dac_tag: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r |-> dac_o_r[12])
    else $error("dac word without channel tag");

endmodule

// ===== sv/lockin_quadrature_accumulator_top.sv =====
// Top level: lock-in I/Q demodulator with excitation DAC word per input word.
//
//  Channel  Direction  Handshake           Content
//  in_ch    sink       valid/ready         op, adc sample, table entry load fields
//  out_ch   source     valid/ready         dac word, I/Q sums, sample count, done
//  cfg_*    sink       write enable only   adc_zero, points/cycle, repeats, target, free run
//
// One word per cycle unless out_ch stalls; words pass stages B, C and the result register.
// Stages: table read and sequencing, 13x16 multiply, 48-bit accumulate into result register.
// Reset (synchronous, rst_n low) clears counters, sums and pipeline valids; table is unset.
// A stalled result holds back the pipe; words keep entering until every stage is full.
module lockin_quadrature_accumulator_top (
  input  logic                        clk,
  input  logic                        rst_n,
  lqa_in_if.sink                      in_ch,
  lqa_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [lqa_pkg::CFG_AW-1:0]  cfg_index,
  input  logic [lqa_pkg::CFG_DW-1:0]  cfg_data
);
  import lqa_pkg::*;

  logic               take;
  logic               can_take;
  op_t                op;
  issue_t             issue;
  logic [TBL_AW-1:0]  rd_idx;
  tbl_entry_t         wr_entry;
  tbl_entry_t         rd_entry;

  assign op             = op_t'(in_ch.op);
  assign in_ch.ready    = can_take;
  assign take           = in_ch.valid && can_take;
  assign wr_entry.excite = in_ch.excite_value;
  assign wr_entry.ref_i  = in_ch.ref_in_phase;
  assign wr_entry.ref_q  = in_ch.ref_quadrature;

  lqa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .take       (take),
    .op         (op),
    .adc_sample (in_ch.adc_sample),
    .issue      (issue),
    .rd_idx     (rd_idx)
  );

  lqa_table u_table (
    .clk     (clk),
    .we      (take && (op == OP_LOAD)),
    .wr_idx  (in_ch.table_index[TBL_AW-1:0]),
    .wr_data (wr_entry),
    .re      (take),
    .rd_idx  (rd_idx),
    .rd_data (rd_entry)
  );

  lqa_mac u_mac (
    .clk            (clk),
    .rst_n          (rst_n),
    .take           (take),
    .issue          (issue),
    .entry          (rd_entry),
    .can_take       (can_take),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .dac_word       (out_ch.dac_word),
    .sum_in_phase   (out_ch.sum_in_phase),
    .sum_quadrature (out_ch.sum_quadrature),
    .samples_taken  (out_ch.samples_taken),
    .done_res       (out_ch.done_res)
  );

endmodule

// ===== test/tb_lockin_quadrature_accumulator_top.sv =====
// Testbench: lock-in quadrature accumulator top, directed and random words checked against a tracking model.
`timescale 1ns / 1ps

module tb_lockin_quadrature_accumulator_top;
  import lqa_pkg::*;

  localparam int          LONG_HOLD   = 300;
  localparam int          STALL_LIMIT = 2000;
  localparam logic [11:0] EXCITE_MID  = 12'h800;

  typedef struct packed {
    logic [12:0]        dac_word;
    logic signed [47:0] sum_i;
    logic signed [47:0] sum_q;
    logic [31:0]        taken;
    logic               done;
  } lqa_word_t;

  class iq_sum_tracker;
    logic [11:0]        adc_zero;
    logic [8:0]         pts_cycle;
    logic [15:0]        pt_repeats;
    logic [23:0]        cyc_target;
    logic               free_run;
    logic [15:0]        rep_cnt;
    logic [8:0]         pos;
    logic [23:0]        cyc_cnt;
    logic signed [47:0] acc_i;
    logic signed [47:0] acc_q;
    logic [31:0]        taken;
    logic [11:0]        last_excite;
    logic [11:0]        excite_tbl [TABLE_DEPTH];
    logic signed [15:0] ref_i_tbl [TABLE_DEPTH];
    logic signed [15:0] ref_q_tbl [TABLE_DEPTH];
    bit                 loaded [TABLE_DEPTH];
    lqa_word_t          due_words [$];
    int                 mismatches;

    function new();
      adc_zero    = ADC_ZERO_RST;
      pts_cycle   = PTS_CYCLE_RST;
      pt_repeats  = PT_REPEATS_RST;
      cyc_target  = CYC_TARGET_RST;
      free_run    = 1'b0;
      rep_cnt     = '0;
      pos         = '0;
      cyc_cnt     = '0;
      acc_i       = '0;
      acc_q       = '0;
      taken       = '0;
      last_excite = '0;
      foreach (loaded[k]) loaded[k] = 1'b0;
      mismatches  = 0;
    endfunction

    function void set_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
      case (idx)
        CFG_ADC_ZERO:   adc_zero   = val[11:0];
        CFG_PTS_CYCLE:  pts_cycle  = val[8:0];
        CFG_PT_REPEATS: pt_repeats = val[15:0];
        CFG_CYC_TARGET: cyc_target = val[23:0];
        CFG_FREE_RUN:   free_run   = val[0];
        default: ;
      endcase
    endfunction

    // entry the next sample will read, if any, and whether it is still unloaded
    function bit entry_missing(output logic [TBL_AW-1:0] e);
      logic [8:0]  p;
      logic [23:0] c;
      p = pos;
      c = cyc_cnt;
      if (p >= pts_cycle) begin
        p = '0;
        if (c != CYC_MAX) c++;
      end
      e = p[TBL_AW-1:0];
      return (c < cyc_target || free_run) && !loaded[e];
    endfunction

    function void take_sample(logic [11:0] adc);
      logic [15:0]        reps;
      logic [TBL_AW-1:0]  e;
      logic signed [12:0] v;
      logic signed [47:0] p_i;
      logic signed [47:0] p_q;
      reps = (pt_repeats == 16'd0) ? 16'd1 : pt_repeats;
      if (pos >= pts_cycle) begin
        pos     = '0;
        rep_cnt = '0;
        if (cyc_cnt != CYC_MAX) cyc_cnt++;
      end
      if (cyc_cnt < cyc_target || free_run) begin
        e   = pos[TBL_AW-1:0];
        v   = $signed({1'b0, adc}) - $signed({1'b0, adc_zero});
        p_i = v * ref_i_tbl[e];
        p_q = v * ref_q_tbl[e];
        acc_i = acc_i + p_i;
        acc_q = acc_q + p_q;
        if (taken != CNT_MAX) taken++;
        rep_cnt++;
        if (rep_cnt >= reps) begin
          rep_cnt = '0;
          pos++;
        end
        last_excite = excite_tbl[e];
      end else begin
        pos     = '0;
        rep_cnt = '0;
      end
    endfunction

    function void note_word(op_t op, logic [11:0] adc, logic [TBL_AW-1:0] idx,
                            logic [11:0] ex, logic [15:0] ri, logic [15:0] rq);
      lqa_word_t   w;
      logic [11:0] mid;
      w = '0;
      case (op)
        OP_SAMPLE: take_sample(adc);
        OP_LOAD: begin
          excite_tbl[idx] = ex;
          ref_i_tbl[idx]  = ri;
          ref_q_tbl[idx]  = rq;
          loaded[idx]     = 1'b1;
        end
        OP_READ: begin
          w.sum_i = acc_i;
          w.sum_q = acc_q;
          w.taken = taken;
          w.done  = cyc_cnt >= cyc_target;
          acc_i   = '0;
          acc_q   = '0;
          taken   = '0;
          cyc_cnt = '0;
        end
        default: ;
      endcase
      mid = last_excite + EXCITE_MID;
      w.dac_word = {1'b1, mid};
      due_words.push_back(w);
    endfunction

    function void check_word(lqa_word_t got);
      lqa_word_t want;
      if (due_words.size() == 0) begin
        $error("result word with none pending, dac_word %h", got.dac_word);
        mismatches++;
        return;
      end
      want = due_words.pop_front();
      if (got.dac_word !== want.dac_word) begin
        $error("dac_word: expected %h, got %h", want.dac_word, got.dac_word);
        mismatches++;
      end
      if (got.sum_i !== want.sum_i) begin
        $error("sum_in_phase: expected %0d, got %0d", want.sum_i, got.sum_i);
        mismatches++;
      end
      if (got.sum_q !== want.sum_q) begin
        $error("sum_quadrature: expected %0d, got %0d", want.sum_q, got.sum_q);
        mismatches++;
      end
      if (got.taken !== want.taken) begin
        $error("samples_taken: expected %0d, got %0d", want.taken, got.taken);
        mismatches++;
      end
      if (got.done !== want.done) begin
        $error("done_res: expected %b, got %b", want.done, got.done);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;
  bit                tx_gaps   = 1'b1;
  bit                rx_stalls = 1'b1;
  bit                hold_off  = 1'b0;
  int                quiet     = 0;
  iq_sum_tracker     sums      = new();

  lqa_in_if  in_ch ();
  lqa_out_if out_ch ();

  lockin_quadrature_accumulator_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin : result_monitor
    lqa_word_t seen;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen = {out_ch.dac_word, out_ch.sum_in_phase, out_ch.sum_quadrature,
              out_ch.samples_taken, out_ch.done_res};
      sums.check_word(seen);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : result_sink
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_off = 1'b0;
      end else if (rx_stalls && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 16)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic [11:0] pick_adc();
    case ($urandom_range(0, 9))
      0:       return 12'h000;
      1:       return 12'hFFF;
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_word(input op_t op, input logic [11:0] adc, input logic [TBL_AW-1:0] idx,
                           input logic [11:0] ex, input logic [15:0] ri, input logic [15:0] rq);
    @(negedge clk);
    in_ch.valid          <= 1'b1;
    in_ch.op             <= op;
    in_ch.adc_sample     <= adc;
    in_ch.table_index    <= idx;
    in_ch.excite_value   <= ex;
    in_ch.ref_in_phase   <= ri;
    in_ch.ref_quadrature <= rq;
    do @(posedge clk); while (!in_ch.ready);
    sums.note_word(op, adc, idx, ex, ri, rq);
    if (tx_gaps && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 16)) @(negedge clk);
    end
  endtask

  task automatic send_bare(input op_t op, input logic [11:0] adc);
    send_word(op, adc, TBL_AW'($urandom), 12'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic load_random(input logic [TBL_AW-1:0] idx);
    logic [15:0] ex;
    ex = pick16();
    send_word(OP_LOAD, 12'($urandom), idx, ex[15:4], pick16(), pick16());
  endtask

  // entries are loaded before their first read
  task automatic send_sample(input logic [11:0] adc);
    logic [TBL_AW-1:0] e;
    if (sums.entry_missing(e)) load_random(e);
    send_bare(OP_SAMPLE, adc);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sums.due_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sums.set_reg(idx, val);
  endtask

  task automatic set_mode(input logic [11:0] zero, input logic [8:0] ppc, input logic [15:0] reps,
                          input logic [23:0] target, input logic run);
    drain();
    write_reg(CFG_ADC_ZERO, CFG_DW'(zero));
    write_reg(CFG_PTS_CYCLE, CFG_DW'(ppc));
    write_reg(CFG_PT_REPEATS, CFG_DW'(reps));
    write_reg(CFG_CYC_TARGET, CFG_DW'(target));
    write_reg(CFG_FREE_RUN, CFG_DW'(run));
  endtask

  task automatic run_phase(input int n, input int read_pct);
    int roll;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < read_pct) send_bare(OP_READ, 12'($urandom));
      else if (roll < read_pct + 10) load_random(TBL_AW'($urandom));
      else if (roll < read_pct + 13) send_bare(OP_NONE, 12'($urandom));
      else send_sample(pick_adc());
    end
  endtask

  initial begin : stimulus
    logic [11:0] adc_corners [5];
    adc_corners          = '{12'hFFF, 12'h000, 12'h800, 12'hFFF, 12'h000};
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.op             = OP_SAMPLE;
    in_ch.adc_sample     = '0;
    in_ch.table_index    = '0;
    in_ch.excite_value   = '0;
    in_ch.ref_in_phase   = '0;
    in_ch.ref_quadrature = '0;
    cfg_we               = 1'b0;
    cfg_index            = CFG_ADC_ZERO;
    cfg_data             = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset settings first
    send_bare(OP_READ, 12'h000);
    send_bare(OP_NONE, 12'hFFF);
    send_word(OP_LOAD, 12'hFFF, 8'd0, 12'h800, 16'h7FFF, 16'h8000);
    send_word(OP_LOAD, 12'h000, 8'd1, 12'h7FF, 16'h8000, 16'h7FFF);
    send_word(OP_LOAD, 12'h555, 8'd255, 12'h000, 16'hFFFF, 16'h0001);
    foreach (adc_corners[k]) send_sample(adc_corners[k]);
    send_bare(OP_READ, 12'h000);
    // one-cycle target: accumulation stops on the wrap
    set_mode(12'hFFF, 9'd2, 16'd1, 24'd1, 1'b0);
    repeat (4) send_sample(pick_adc());
    send_bare(OP_READ, 12'hFFF);
    send_sample(12'h800);
    send_bare(OP_READ, 12'h000);

    // zero points and repeats, free running
    set_mode(12'h000, 9'd0, 16'd0, 24'd0, 1'b1);
    run_phase(150, 10);
    // full table, longest target, receiver held off
    set_mode(12'hFFF, 9'd256, 16'd1, 24'hFFFFFF, 1'b0);
    hold_off = 1'b1;
    run_phase(250, 3);
    // positions past the table end
    set_mode(12'($urandom), 9'h1FF, 16'd1, 24'd3, 1'b0);
    run_phase(220, 2);
    drain();
    run_phase(220, 2);

    for (int k = 0; k < 6; k++) begin
      set_mode(12'($urandom), 9'($urandom_range(0, 6)),
               (k == 0) ? 16'hFFFF : 16'($urandom_range(0, 3)),
               24'($urandom_range(0, 12)), $urandom_range(0, 3) == 0);
      tx_gaps   = $urandom_range(0, 3) != 0;
      rx_stalls = $urandom_range(0, 3) != 0;
      run_phase(120, $urandom_range(3, 20));
    end

    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    set_mode(12'($urandom), 9'd3, 16'd1, 24'd4, 1'b0);
    run_phase(200, 8);

    drain();
    repeat (10) @(posedge clk);
    if (sums.mismatches == 0 && sums.due_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/lqa_pkg.sv
sv/lqa_if.sv
sv/lqa_ctrl.sv
sv/lqa_table.sv
sv/lqa_mac.sv
sv/lockin_quadrature_accumulator_top.sv
test/tb_lockin_quadrature_accumulator_top.sv
